// ===== hw/rtl/hhlt_pkg.sv =====
// hhlt_pkg: types, codes and the name-character fold for the header line tokeniser.
// No dependencies; imported by hhlt_step and http_header_line_tokenizer.
package hhlt_pkg;

  typedef enum logic [2:0] {
    ST_LINE_START = 3'd0,
    ST_NAME       = 3'd1,
    ST_SPACE      = 3'd2,
    ST_VALUE      = 3'd3,
    ST_ALMOST     = 3'd4,
    ST_HDR_ALMOST = 3'd5,
    ST_DONE       = 3'd6
  } parse_state_t;

  typedef enum logic [2:0] {
    EV_CONSUMED = 3'd0,
    EV_NAME     = 3'd1,
    EV_VALUE    = 3'd2,
    EV_LINE     = 3'd3,
    EV_HEADERS  = 3'd4,
    EV_ERROR    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_NAME  = 2'd1,
    ERR_VALUE = 2'd2,
    ERR_EOL   = 2'd3
  } err_t;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Parser state carried from word to word
  typedef struct packed {
    parse_state_t parse_state;
    logic         invalid_flag;
    err_t         error_code;
  } hhlt_state_t;

  // One result word
  typedef struct packed {
    event_t     event_res;
    logic [7:0] data_out;
    err_t       error_kind;
    logic       name_invalid;
  } hhlt_res_t;

  // Lower-cased name character, or zero when not a valid name character
  function automatic logic [7:0] fold_name(input logic [7:0] ch);
    logic [7:0] r;
    r = 8'h00;
    if (ch >= "A" && ch <= "Z") r = ch + CASE_BIT;
    else if (ch >= "a" && ch <= "z") r = ch;
    else if (ch >= "0" && ch <= "9") r = ch;
    else if (ch == "-" || ch == "_") r = ch;
    return r;
  endfunction

endpackage

// ===== hw/rtl/hhlt_step.sv =====
// hhlt_step: next-state and result logic for one header byte or restart word.
// Depends on hhlt_pkg.
module hhlt_step (
  input  hhlt_pkg::hhlt_state_t st,
  input  logic                  cmd,
  input  logic [7:0]            ch,
  output hhlt_pkg::hhlt_state_t st_next,
  output hhlt_pkg::hhlt_res_t   res
);
  import hhlt_pkg::*;

  logic [7:0] low;
  event_t     ev;
  logic [7:0] dat;

  assign low = fold_name(ch);

  always_comb begin
    st_next = st;
    ev      = EV_CONSUMED;
    dat     = 8'h00;
    if (cmd == CMD_RESTART) begin
      st_next.parse_state  = ST_LINE_START;
      st_next.invalid_flag = 1'b0;
      st_next.error_code   = ERR_NONE;
    end else if (st.error_code != ERR_NONE) begin
      ev = EV_ERROR;
    end else begin
      case (st.parse_state)
        ST_LINE_START: begin
          st_next.invalid_flag = 1'b0;
          if (ch == CH_CR) begin
            st_next.parse_state = ST_HDR_ALMOST;
          end else if (ch == CH_LF) begin
            st_next.parse_state = ST_DONE;
            ev = EV_HEADERS;
          end else begin
            st_next.parse_state = ST_NAME;
            if (low != 8'h00) begin
              ev  = EV_NAME;
              dat = low;
            end else if (ch <= CH_SPACE || ch == CH_DEL || ch == CH_COLON) begin
              st_next.error_code = ERR_NAME;
            end else begin
              st_next.invalid_flag = 1'b1;
            end
          end
        end
        ST_NAME: begin
          if (low != 8'h00) begin
            ev  = EV_NAME;
            dat = low;
          end else if (ch == CH_COLON) begin
            st_next.parse_state = ST_SPACE;
          end else if (ch == CH_CR) begin
            st_next.parse_state = ST_ALMOST;
          end else if (ch == CH_LF) begin
            st_next.parse_state = ST_LINE_START;
            ev = EV_LINE;
          end else if (ch <= CH_SPACE || ch == CH_DEL) begin
            st_next.error_code = ERR_NAME;
          end else begin
            st_next.invalid_flag = 1'b1;
          end
        end
        ST_SPACE, ST_VALUE: begin
          if (ch == CH_SPACE && st.parse_state == ST_SPACE) begin
            // leading space, skipped
          end else if (ch == CH_CR) begin
            st_next.parse_state = ST_ALMOST;
          end else if (ch == CH_LF) begin
            st_next.parse_state = ST_LINE_START;
            ev = EV_LINE;
          end else if (ch == CH_NUL) begin
            st_next.error_code = (st.parse_state == ST_SPACE) ? ERR_NAME : ERR_VALUE;
          end else begin
            st_next.parse_state = ST_VALUE;
            ev  = EV_VALUE;
            dat = ch;
          end
        end
        ST_ALMOST: begin
          if (ch == CH_LF) begin
            st_next.parse_state = ST_LINE_START;
            ev = EV_LINE;
          end else if (ch != CH_CR) begin
            st_next.error_code = ERR_EOL;
          end
        end
        ST_HDR_ALMOST: begin
          if (ch == CH_LF) begin
            st_next.parse_state = ST_DONE;
            ev = EV_HEADERS;
          end else begin
            st_next.error_code = ERR_EOL;
          end
        end
        default: begin
          // done, and the unreachable code: bytes are ignored
        end
      endcase
      if (st_next.error_code != ERR_NONE) begin
        ev  = EV_ERROR;
        dat = 8'h00;
      end
    end
    res.event_res    = ev;
    res.data_out     = dat;
    res.error_kind   = st_next.error_code;
    res.name_invalid = st_next.invalid_flag;
  end

endmodule

// ===== hw/rtl/http_header_line_tokenizer.sv =====
// http_header_line_tokenizer: top level of the HTTP header byte classifier.
// Depends on hhlt_pkg and hhlt_step.

// Takes one word per cycle, unless stalled, on the src channel (a header byte, or
// a restart command) and returns exactly one result word per input word on the res
// channel, registered in the cycle after acceptance. Throughput is one word per
// clock unless src_stall is high: the parser state update and classification are
// a single short decode in hhlt_step, feeding both the state register and the
// result register. The result register lets a new word be taken in the same cycle
// the previous result leaves; src_stall is raised only while a result is held and
// res_stall is high. Errors and the done state are sticky until a restart word.
module http_header_line_tokenizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  logic                cmd,
  input  logic [7:0]          data_in,
  output logic                res_valid,
  input  logic                res_stall,
  output hhlt_pkg::event_t    event_res,
  output logic [7:0]          data_out,
  output hhlt_pkg::err_t      error_kind,
  output logic                name_invalid
);
  import hhlt_pkg::*;

  hhlt_state_t st;
  hhlt_state_t st_next;
  hhlt_res_t   res_next;
  hhlt_res_t   res;
  logic        take;

  // Result register full and not draining: hold the source
  assign src_stall = res_valid & res_stall;
  assign take      = src_valid & ~src_stall;

  hhlt_step u_step (
    .st      (st),
    .cmd     (cmd),
    .ch      (data_in),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.parse_state  <= ST_LINE_START;
      st.invalid_flag <= 1'b0;
      st.error_code   <= ERR_NONE;
      res_valid       <= 1'b0;
    end else begin
      if (take) begin
        st        <= st_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign event_res    = res.event_res;
  assign data_out     = res.data_out;
  assign error_kind   = res.error_kind;
  assign name_invalid = res.name_invalid;

`ifndef NO_ASSERTIONS
  // A stored error survives until a restart word
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.error_code != ERR_NONE && !(take && cmd == CMD_RESTART))
    |=> st.error_code == $past(st.error_code))
    else $error("error code changed without restart");

  // An error result always carries its kind
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res == EV_ERROR) |-> error_kind != ERR_NONE)
    else $error("error event with no error kind");

  // Byte data only accompanies name or value events
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res != EV_NAME && event_res != EV_VALUE) |-> data_out == 8'h00)
    else $error("data on a non-byte event");

  // Every accepted word produces a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    take |=> res_valid)
    else $error("accepted word produced no result");
`endif

endmodule
